>>> rtl/trsc_pkg.sv
// Shared constants, types and helper functions for the thermostat setpoint and relay control.
`timescale 1ns / 1ps
package trsc_pkg;

	// Field widths and setpoint range.
	localparam int SAMPLE_BITS  = 10;
	localparam int SETPOINT_MIN = 10;
	localparam int SETPOINT_MAX = 20;
	localparam int SP_W         = 5;
	localparam int DEB_W        = 10;
	localparam int BAND_W       = 8;
	localparam int RLIM_W       = 4;
	localparam int BEEP_W       = 10;
	localparam int SAVE_W       = 8;
	localparam int CFG_DATA_W   = 10;
	localparam int CFG_IDX_W    = 3;

	// Sample window center: (setpoint - REF_TEMP) * REF_STEP + REF_BASE.
	localparam int REF_TEMP   = 10;
	localparam int REF_STEP   = 20;
	localparam int REF_BASE   = 500;
	localparam int REF_OFFSET = REF_BASE - REF_TEMP * REF_STEP;
	localparam int CMP_W      = ((SAMPLE_BITS > 11) ? SAMPLE_BITS : 11) + 1;

	// Register reset values.
	localparam int DEBOUNCE_LIMIT_RESET    = 500;
	localparam int BAND_HALF_WIDTH_RESET   = 15;
	localparam int RELAY_COUNT_LIMIT_RESET = 10;
	localparam int LONG_BEEP_RESET         = 1000;
	localparam int SHORT_BEEP_RESET        = 50;
	localparam int SAVE_DELAY_RESET        = 20;
	localparam int SETPOINT_RESET          = (SETPOINT_MIN + SETPOINT_MAX) / 2;
	localparam int FILTER_RESET            = DEBOUNCE_LIMIT_RESET / 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_LIMIT    = 3'd0,
		CFG_BAND_HALF_WIDTH   = 3'd1,
		CFG_RELAY_COUNT_LIMIT = 3'd2,
		CFG_LONG_BEEP_TICKS   = 3'd3,
		CFG_SHORT_BEEP_TICKS  = 3'd4,
		CFG_SAVE_DELAY_TICKS  = 3'd5,
		CFG_INITIAL_SETPOINT  = 3'd6
	} cfg_index_t;

	// Requests from the setpoint logic to the tone unit.
	typedef struct packed {
		logic [BEEP_W-1:0] beep_len;
		logic              save_arm;
	} tone_req_t;

	// Levels from the tone unit after the tick.
	typedef struct packed {
		logic buzzer;
		logic save_pulse;
	} tone_out_t;

	// Outcome of one setpoint step.
	typedef struct packed {
		logic [SP_W-1:0] sp;
		logic            changed;
	} sp_step_t;

	// Step the setpoint by one within its range; at a limit it stays put.
	function automatic sp_step_t step_setpoint(input logic [SP_W-1:0] sp, input logic up);
		sp_step_t r;
		if (up) begin
			if (sp < SP_W'(SETPOINT_MAX)) begin
				r.sp      = sp + SP_W'(1);
				r.changed = 1'b1;
			end else begin
				r.sp      = SP_W'(SETPOINT_MAX);
				r.changed = 1'b0;
			end
		end else begin
			if (sp > SP_W'(SETPOINT_MIN)) begin
				r.sp      = sp - SP_W'(1);
				r.changed = 1'b1;
			end else begin
				r.sp      = SP_W'(SETPOINT_MIN);
				r.changed = 1'b0;
			end
		end
		return r;
	endfunction

	// A stored setpoint outside the range loads the middle of the range.
	function automatic logic [SP_W-1:0] load_setpoint(input logic [SP_W-1:0] v);
		if (v > SP_W'(SETPOINT_MAX) || v < SP_W'(SETPOINT_MIN)) begin
			return SP_W'(SETPOINT_RESET);
		end
		return v;
	endfunction

	// Larger of two beep lengths.
	function automatic logic [BEEP_W-1:0] max_beep(input logic [BEEP_W-1:0] a,
			input logic [BEEP_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

>>> rtl/trsc_debounce.sv
// Integrating button debounce with a re-arm latch.
`timescale 1ns / 1ps
module trsc_debounce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      released,
	input  logic [trsc_pkg::DEB_W-1:0] limit,
	output logic                      fire
);
	import trsc_pkg::*;

	logic [DEB_W-1:0] filter_q, filter_d;
	logic             latched_q, latched_d;

	// Filter integrates while pressed, drains while released.
	always_comb begin
		filter_d  = filter_q;
		latched_d = latched_q;
		fire      = 1'b0;
		if (released) begin
			if (filter_q != '0) begin
				filter_d = filter_q - DEB_W'(1);
				if (filter_d == '0) begin
					latched_d = 1'b0;
				end
			end
		end else if (filter_q < limit) begin
			filter_d = filter_q + DEB_W'(1);
			if (filter_d >= limit && !latched_q) begin
				latched_d = 1'b1;
				fire      = 1'b1;
			end
		end
	end

	// State advances only when en is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q  <= DEB_W'(FILTER_RESET);
			latched_q <= 1'b0;
		end else if (en) begin
			filter_q  <= filter_d;
			latched_q <= latched_d;
		end
	end

endmodule

>>> rtl/trsc_relay.sv
// Sample window compare and hysteresis counter for the cooling relay.
`timescale 1ns / 1ps
module trsc_relay (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             sample_valid,
	input  logic [trsc_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [trsc_pkg::SP_W-1:0]        setpoint,
	input  logic [trsc_pkg::BAND_W-1:0]      band,
	input  logic [trsc_pkg::RLIM_W-1:0]      limit,
	output logic                             relay_next
);
	import trsc_pkg::*;

	logic [RLIM_W-1:0] count_q, count_d;
	logic              relay_q;
	logic [CMP_W-1:0]  center, hi, lo, smp;

	// Window bounds around the setpoint reference; all values stay positive.
	always_comb begin
		center = CMP_W'(setpoint) * CMP_W'(REF_STEP) + CMP_W'(REF_OFFSET);
		hi     = center + CMP_W'(band);
		lo     = center - CMP_W'(band);
		smp    = CMP_W'(sample);
	end

	// Samples above the window count up toward the limit, samples below count down to zero.
	always_comb begin
		count_d    = count_q;
		relay_next = relay_q;
		if (sample_valid) begin
			if (smp > hi) begin
				if (count_q < limit) begin
					count_d = count_q + RLIM_W'(1);
				end
				if (!relay_q && count_d >= limit) begin
					relay_next = 1'b1;
				end
			end else if (smp < lo) begin
				if (count_q != '0) begin
					count_d = count_q - RLIM_W'(1);
				end
				if (relay_q && count_d == '0) begin
					relay_next = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			relay_q <= 1'b0;
		end else if (en) begin
			count_q <= count_d;
			relay_q <= relay_next;
		end
	end

endmodule

>>> rtl/trsc_tone.sv
// Beep counter, buzzer toggle and save delay on the tone time base.
`timescale 1ns / 1ps
module trsc_tone (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        tone_tick,
	input  trsc_pkg::tone_req_t         req,
	input  logic [trsc_pkg::SAVE_W-1:0] save_delay,
	output trsc_pkg::tone_out_t         tone
);
	import trsc_pkg::*;

	logic [BEEP_W-1:0] beep_q, beep_d;
	logic [SAVE_W-1:0] save_q, save_d;
	logic              buzz_q, buzz_d;

	// Apply button requests first, then the tone tick.
	always_comb begin
		beep_d          = max_beep(beep_q, req.beep_len);
		save_d          = req.save_arm ? save_delay : save_q;
		buzz_d          = buzz_q;
		tone.save_pulse = 1'b0;
		if (tone_tick) begin
			if (beep_d != '0) begin
				beep_d = beep_d - BEEP_W'(1);
				buzz_d = !buzz_q;
			end
			if (save_d != '0) begin
				save_d          = save_d - SAVE_W'(1);
				tone.save_pulse = (save_d == '0);
			end
		end
		tone.buzzer = buzz_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beep_q <= '0;
			save_q <= '0;
			buzz_q <= 1'b0;
		end else if (en) begin
			beep_q <= beep_d;
			save_q <= save_d;
			buzz_q <= buzz_d;
		end
	end

endmodule

>>> rtl/thermostat_setpoint_relay_control.sv
// Top level: input register, per-tick control logic and result register.
// While a result waits, one more item can still enter the input register.
// Throughput: one item per cycle unless in_stall is high.
// The setpoint, relay and tone state advance in the cycle an item moves
// from the input register into the result register.
// Reset loads control state and valid flags; the data registers have no reset.
`timescale 1ns / 1ps
module thermostat_setpoint_relay_control (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                up_released,
	input  logic                                down_released,
	input  logic                                sample_valid,
	input  logic [trsc_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic                                tone_tick,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                relay_on,
	output logic                                buzzer_level,
	output logic [trsc_pkg::SP_W-1:0]           setpoint,
	output logic                                save_request,
	input  logic                                cfg_write,
	input  logic [trsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [trsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import trsc_pkg::*;

	// Configuration registers.
	logic [DEB_W-1:0]  debounce_limit_q;
	logic [BAND_W-1:0] band_half_width_q;
	logic [RLIM_W-1:0] relay_count_limit_q;
	logic [BEEP_W-1:0] long_beep_q;
	logic [BEEP_W-1:0] short_beep_q;
	logic [SAVE_W-1:0] save_delay_q;

	// Input register.
	logic                   valid_s1;
	logic                   up_released_s1;
	logic                   down_released_s1;
	logic                   sample_valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   tone_tick_s1;

	// Result register.
	logic            out_valid_q;
	logic            relay_on_q;
	logic            buzzer_q;
	logic [SP_W-1:0] setpoint_q;
	logic            save_request_q;

	// Setpoint state and per-tick signals.
	logic [SP_W-1:0] cur_sp_q;
	logic            advance;
	logic            in_accept;
	logic            up_fire;
	logic            down_fire;
	logic            relay_next;
	sp_step_t        up_step;
	sp_step_t        down_step;
	logic [SP_W-1:0] sp_after_up;
	logic [SP_W-1:0] sp_next;
	tone_req_t       tone_req;
	tone_out_t       tone;

	// The input register empties when the result register is free or drains.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			up_released_s1   <= up_released;
			down_released_s1 <= down_released;
			sample_valid_s1  <= sample_valid;
			sample_s1        <= sample;
			tone_tick_s1     <= tone_tick;
		end
	end

	// Sample check against the setpoint before any button step.
	trsc_relay u_relay (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.sample_valid (sample_valid_s1),
		.sample       (sample_s1),
		.setpoint     (cur_sp_q),
		.band         (band_half_width_q),
		.limit        (relay_count_limit_q),
		.relay_next   (relay_next)
	);

	trsc_debounce u_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.released (up_released_s1),
		.limit    (debounce_limit_q),
		.fire     (up_fire)
	);

	trsc_debounce u_down (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.released (down_released_s1),
		.limit    (debounce_limit_q),
		.fire     (down_fire)
	);

	// Up press, then down press; each press asks for a beep, a long one at a limit.
	always_comb begin
		up_step     = step_setpoint(cur_sp_q, 1'b1);
		sp_after_up = up_fire ? up_step.sp : cur_sp_q;
		down_step   = step_setpoint(sp_after_up, 1'b0);
		sp_next     = down_fire ? down_step.sp : sp_after_up;
		tone_req.beep_len = '0;
		tone_req.save_arm = 1'b0;
		if (up_fire) begin
			tone_req.beep_len = up_step.changed ? short_beep_q : long_beep_q;
			tone_req.save_arm = up_step.changed;
		end
		if (down_fire) begin
			tone_req.beep_len = max_beep(tone_req.beep_len,
				down_step.changed ? short_beep_q : long_beep_q);
			tone_req.save_arm = tone_req.save_arm || down_step.changed;
		end
	end

	trsc_tone u_tone (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.tone_tick  (tone_tick_s1),
		.req        (tone_req),
		.save_delay (save_delay_q),
		.tone       (tone)
	);

	// Configuration writes; a setpoint write only loads the current setpoint.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q    <= DEB_W'(DEBOUNCE_LIMIT_RESET);
			band_half_width_q   <= BAND_W'(BAND_HALF_WIDTH_RESET);
			relay_count_limit_q <= RLIM_W'(RELAY_COUNT_LIMIT_RESET);
			long_beep_q         <= BEEP_W'(LONG_BEEP_RESET);
			short_beep_q        <= BEEP_W'(SHORT_BEEP_RESET);
			save_delay_q        <= SAVE_W'(SAVE_DELAY_RESET);
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_DEBOUNCE_LIMIT: begin
					debounce_limit_q <= cfg_data[DEB_W-1:0];
				end
				CFG_BAND_HALF_WIDTH: begin
					band_half_width_q <= cfg_data[BAND_W-1:0];
				end
				CFG_RELAY_COUNT_LIMIT: begin
					relay_count_limit_q <= cfg_data[RLIM_W-1:0];
				end
				CFG_LONG_BEEP_TICKS: begin
					long_beep_q <= cfg_data[BEEP_W-1:0];
				end
				CFG_SHORT_BEEP_TICKS: begin
					short_beep_q <= cfg_data[BEEP_W-1:0];
				end
				CFG_SAVE_DELAY_TICKS: begin
					save_delay_q <= cfg_data[SAVE_W-1:0];
				end
				default: begin
					// The stored setpoint is loaded into the current setpoint below.
				end
			endcase
		end
	end

	// Current setpoint: loaded by a configuration write, stepped by buttons.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_sp_q <= SP_W'(SETPOINT_RESET);
		end else if (cfg_write && cfg_index_t'(cfg_index) == CFG_INITIAL_SETPOINT) begin
			cur_sp_q <= load_setpoint(cfg_data[SP_W-1:0]);
		end else if (advance) begin
			cur_sp_q <= sp_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			relay_on_q     <= relay_next;
			buzzer_q       <= tone.buzzer;
			setpoint_q     <= sp_next;
			save_request_q <= tone.save_pulse;
		end
	end

	assign out_valid    = out_valid_q;
	assign relay_on     = relay_on_q;
	assign buzzer_level = buzzer_q;
	assign setpoint     = setpoint_q;
	assign save_request = save_request_q;

endmodule

>>> rtl/trsc_checker.sv
// Port-level checker for the thermostat control, bound to the top level.
`timescale 1ns / 1ps
module trsc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [trsc_pkg::SP_W-1:0]        setpoint,
	input logic                             save_request
);
	import trsc_pkg::*;

	// A held result stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// The input side only stalls when the output side holds a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");

	// The setpoint shown always lies within its range.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> setpoint >= SP_W'(SETPOINT_MIN) && setpoint <= SP_W'(SETPOINT_MAX))
		else $error("setpoint out of range");

	// A stalled result keeps its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(setpoint) && $stable(save_request))
		else $error("result changed while stalled");

endmodule

bind thermostat_setpoint_relay_control trsc_checker u_trsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.setpoint     (setpoint),
	.save_request (save_request)
);
